### hdl/pbo_pkg.sv
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared types and constants of the band-limited oscillator.
// ----------------------------------------------------------------------------
package pbo_pkg;

    localparam int PBO_PHASE_BITS       = 24;
    localparam int PBO_SINE_TABLE_BITS  = 10;

    localparam int INC_W      = 24;
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 18;
    localparam int WAVE_W     = 2;
    localparam int QUOTIENT_W = 16;

    localparam int QUEUE_DEPTH   = 2;
    localparam int PIPE_CAPACITY = 2 * QUEUE_DEPTH + 1;

    typedef logic [WAVE_W-1:0] t_wave;
    typedef logic [1:0]        t_blep;

    localparam t_wave WAVE_SAW      = 2'd0;
    localparam t_wave WAVE_SQUARE   = 2'd1;
    localparam t_wave WAVE_TRIANGLE = 2'd2;
    localparam t_wave WAVE_SINE     = 2'd3;

    localparam t_blep BLEP_NONE = 2'd0;
    localparam t_blep BLEP_NEG  = 2'd1;
    localparam t_blep BLEP_POS  = 2'd2;

    localparam logic signed [ACC_W-1:0] POS_FULL   = 18'sd32768;
    localparam logic signed [ACC_W-1:0] NEG_FULL   = -18'sd32768;
    localparam logic signed [ACC_W-1:0] SAMPLE_MAX = 18'sd32767;
    localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -18'sd32768;

    typedef struct packed {
        t_wave wave;
        t_blep kind_a;
        t_blep kind_b;
    } t_ctl;

endpackage

### hdl/pbo_fifo.sv
// ----------------------------------------------------------------------------
// pbo_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module pbo_fifo #(
    parameter int WIDTH = pbo_pkg::SAMPLE_W,
    parameter int DEPTH = pbo_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_wr      = i_wr_en & ~o_full;
    assign w_rd      = i_rd_en & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### hdl/pbo_front.sv
// ----------------------------------------------------------------------------
// pbo_front
// Phase accumulator and sample classification: base waveform value,
// BLEP region and divider operands for each transaction.
// ----------------------------------------------------------------------------
module pbo_front #(
    parameter int PHASE_BITS      = pbo_pkg::PBO_PHASE_BITS,
    parameter int SINE_TABLE_BITS = pbo_pkg::PBO_SINE_TABLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [pbo_pkg::INC_W-1:0]           i_phase_increment,
    input  logic                                i_restart,
    input  pbo_pkg::t_wave                      i_waveform_select,
    input  logic                                i_queue_full,
    output logic                                o_cmd_push,
    output pbo_pkg::t_ctl                       o_ctl,
    output logic [PHASE_BITS-1:0]               o_divisor,
    output logic [PHASE_BITS-1:0]               o_num_a,
    output logic [PHASE_BITS-1:0]               o_num_b,
    output logic signed [pbo_pkg::ACC_W-1:0]    o_base,
    output logic [SINE_TABLE_BITS-1:0]          o_sine_idx
);
    import pbo_pkg::*;

    localparam int MSB = PHASE_BITS - 1;

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [PHASE_BITS-1:0] w_p, w_p2, w_d, w_dist, w_half;
    logic [PHASE_BITS+1:0] w_class_a, w_class_b;
    logic [16:0]           w_tri;
    logic                  w_accept;

    function automatic logic [PHASE_BITS+1:0] classify(
        input logic [PHASE_BITS-1:0] p,
        input logic [PHASE_BITS-1:0] d
    );
        logic [PHASE_BITS:0]   sum;
        logic [PHASE_BITS+1:0] res;
        sum = {1'b0, p} + {1'b0, d};
        res = {BLEP_NONE, {PHASE_BITS{1'b0}}};
        if (d != '0) begin
            if (p < d) begin
                res = {BLEP_NEG, d - p};
            end else if (sum[PHASE_BITS] && (sum[PHASE_BITS-1:0] != '0)) begin
                res = {BLEP_POS, sum[PHASE_BITS-1:0]};
            end
        end
        return res;
    endfunction

    assign o_full     = i_queue_full | ~i_rst_n;
    assign w_accept   = i_push & ~o_full;
    assign o_cmd_push = w_accept;

    assign w_d    = PHASE_BITS'(i_phase_increment);
    assign w_p    = i_restart ? '0 : r_phase;
    assign w_p2   = {~w_p[MSB], w_p[MSB-1:0]};
    assign w_half = {1'b1, {(PHASE_BITS-1){1'b0}}};
    assign w_dist = w_p[MSB] ? {1'b0, w_p[MSB-1:0]} : w_half - w_p;
    assign w_tri  = 17'({w_dist, 1'b0} >> (PHASE_BITS - 16));

    assign w_class_a = classify(w_p, w_d);
    assign w_class_b = classify(w_p2, w_d);

    assign o_divisor  = w_d;
    assign o_num_a    = w_class_a[PHASE_BITS-1:0];
    assign o_num_b    = w_class_b[PHASE_BITS-1:0];
    assign o_sine_idx = w_p[MSB -: SINE_TABLE_BITS];

    always_comb begin
        o_ctl.wave   = i_waveform_select;
        o_ctl.kind_a = BLEP_NONE;
        o_ctl.kind_b = BLEP_NONE;
        o_base       = '0;
        case (i_waveform_select)
            WAVE_SAW: begin
                o_ctl.kind_a = w_class_a[PHASE_BITS+1:PHASE_BITS];
                o_base       = $signed({2'b00, w_p[MSB -: 16]}) - POS_FULL;
            end
            WAVE_SQUARE: begin
                o_ctl.kind_a = w_class_a[PHASE_BITS+1:PHASE_BITS];
                o_ctl.kind_b = w_class_b[PHASE_BITS+1:PHASE_BITS];
                o_base       = w_p[MSB] ? NEG_FULL : POS_FULL;
            end
            WAVE_TRIANGLE: begin
                o_base = POS_FULL - $signed({1'b0, w_tri});
            end
            default: begin
                o_base = '0;
            end
        endcase
    end

    assign n_phase = w_p + w_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

### hdl/pbo_sine_rom.sv
// ----------------------------------------------------------------------------
// pbo_sine_rom
// Full-cycle sine lookup from a quarter-wave table, registered read.
// ----------------------------------------------------------------------------
module pbo_sine_rom #(
    parameter int TABLE_BITS = pbo_pkg::PBO_SINE_TABLE_BITS
) (
    input  logic                                 i_clk,
    input  logic [TABLE_BITS-1:0]                i_idx,
    output logic signed [pbo_pkg::SAMPLE_W-1:0]  o_data
);
    import pbo_pkg::*;

    localparam int QUARTER = 2 ** (TABLE_BITS - 2);
    localparam int K_W     = TABLE_BITS - 1;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    function automatic logic [63:0] series_step(input logic [63:0] t, input logic [63:0] x);
        return (((t * x) >> 30) * x) >> 30;
    endfunction

    // Taylor series of sin on a Q30 angle, rounded to Q15
    function automatic logic [14:0] quarter_sine(input int k, input int tb);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (PI_Q30 * 64'(k)) >> (tb - 1);
        term = x;
        sum  = $signed(x);
        term = series_step(term, x) / 64'd6;   sum = sum - $signed(term);
        term = series_step(term, x) / 64'd20;  sum = sum + $signed(term);
        term = series_step(term, x) / 64'd42;  sum = sum - $signed(term);
        term = series_step(term, x) / 64'd72;  sum = sum + $signed(term);
        term = series_step(term, x) / 64'd110; sum = sum - $signed(term);
        term = series_step(term, x) / 64'd156; sum = sum + $signed(term);
        term = series_step(term, x) / 64'd210; sum = sum - $signed(term);
        term = series_step(term, x) / 64'd272; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32767) begin
            sum = 64'sd32767;
        end
        return sum[14:0];
    endfunction

    logic [14:0]      w_quarter [QUARTER+1];
    logic [1:0]       w_quad;
    logic [K_W-1:0]   w_k;
    logic [14:0]      r_mag;
    logic             r_neg;

    for (genvar g = 0; g <= QUARTER; g++) begin : g_quarter
        localparam logic [14:0] VAL = quarter_sine(g, TABLE_BITS);
        assign w_quarter[g] = VAL;
    end

    assign w_quad = i_idx[TABLE_BITS-1 -: 2];
    assign w_k    = w_quad[0] ? K_W'(QUARTER) - {1'b0, i_idx[TABLE_BITS-3:0]}
                              : {1'b0, i_idx[TABLE_BITS-3:0]};

    always_ff @(posedge i_clk) begin
        r_mag <= w_quarter[w_k];
        r_neg <= w_quad[1];
    end

    assign o_data = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

### hdl/pbo_back.sv
// ----------------------------------------------------------------------------
// pbo_back
// Sample renderer: serial divider and squarer for the BLEP terms,
// accumulation, saturation and sine lookup.
// ----------------------------------------------------------------------------
module pbo_back #(
    parameter int PHASE_BITS      = pbo_pkg::PBO_PHASE_BITS,
    parameter int SINE_TABLE_BITS = pbo_pkg::PBO_SINE_TABLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_empty,
    output logic                                o_cmd_pop,
    input  pbo_pkg::t_ctl                       i_ctl,
    input  logic [PHASE_BITS-1:0]               i_divisor,
    input  logic [PHASE_BITS-1:0]               i_num_a,
    input  logic [PHASE_BITS-1:0]               i_num_b,
    input  logic signed [pbo_pkg::ACC_W-1:0]    i_base,
    input  logic [SINE_TABLE_BITS-1:0]          i_sine_idx,
    input  logic                                i_res_full,
    output logic                                o_res_push,
    output logic [pbo_pkg::SAMPLE_W-1:0]        o_res_data
);
    import pbo_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int CNT_W = $clog2(QUOTIENT_W);

    logic [2:0]                   r_state;
    logic                         r_slot;
    t_ctl                         r_ctl;
    logic [PHASE_BITS-1:0]        r_div, r_num_a, r_num_b, r_rem;
    logic signed [ACC_W-1:0]      r_acc;
    logic [SINE_TABLE_BITS-1:0]   r_idx;
    logic [QUOTIENT_W-1:0]        r_quo;
    logic [CNT_W-1:0]             r_cnt;
    logic [QUOTIENT_W:0]          r_sq;

    t_blep                        w_kind;
    logic [PHASE_BITS-1:0]        w_num;
    logic [PHASE_BITS:0]          w_trial, w_diff;
    logic                         w_ge;
    logic [2*QUOTIENT_W-1:0]      w_prod;
    logic                         w_sub;
    logic signed [SAMPLE_W-1:0]   w_sine;
    logic signed [ACC_W-1:0]      w_sat;

    pbo_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_idx  (r_idx),
        .o_data (w_sine)
    );

    assign w_kind  = r_slot ? r_ctl.kind_b : r_ctl.kind_a;
    assign w_num   = r_slot ? r_num_b : r_num_a;
    assign w_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_prod  = r_quo * r_quo;
    assign w_sub   = (w_kind == BLEP_NEG) ^ (r_slot || (r_ctl.wave == WAVE_SAW));

    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;

    always_comb begin
        if (r_acc > SAMPLE_MAX) begin
            w_sat = SAMPLE_MAX;
        end else if (r_acc < SAMPLE_MIN) begin
            w_sat = SAMPLE_MIN;
        end else begin
            w_sat = r_acc;
        end
    end

    assign o_res_data = (r_ctl.wave == WAVE_SINE) ? w_sine : w_sat[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_slot  <= 1'b0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (w_kind == BLEP_NONE) begin
                        if (r_slot) begin
                            r_state <= S_OUT;
                        end else begin
                            r_slot <= 1'b1;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(QUOTIENT_W - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_slot) begin
                        r_state <= S_OUT;
                    end else begin
                        r_slot  <= 1'b1;
                        r_state <= S_START;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    r_ctl   <= i_ctl;
                    r_div   <= i_divisor;
                    r_num_a <= i_num_a;
                    r_num_b <= i_num_b;
                    r_acc   <= i_base;
                    r_idx   <= i_sine_idx;
                end
            end
            S_START: begin
                r_rem <= w_num;
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[PHASE_BITS-1:0] : w_trial[PHASE_BITS-1:0];
                r_quo <= {r_quo[QUOTIENT_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_MUL: begin
                r_sq <= w_prod[2*QUOTIENT_W-1:QUOTIENT_W-1];
            end
            S_ADD: begin
                r_acc <= w_sub ? r_acc - $signed({1'b0, r_sq}) : r_acc + $signed({1'b0, r_sq});
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/polyblep_oscillator.sv
// ----------------------------------------------------------------------------
// polyblep_oscillator
// Band-limited oscillator: saw and square with polyBLEP edges, triangle, sine.
//
// Input side is a queue: a sample tick (increment, restart) is taken when
// push is high and full is low. Result side is a queue: o_sample_out holds
// the oldest sample while empty is low; pop takes it. The waveform select
// register is written through i_cfg_valid / o_cfg_ready; the user must write
// it only while idle, as the block itself does not enforce this.
// A transaction passes the front (phase, classification) in its accept cycle
// and waits in a two-entry command queue for the renderer.
// Triangle, sine and edge-free samples skip the divider; a saw sample near
// its edge uses it once and a square sample near both edges twice, as the
// 16-step serial divider is shared by the two BLEP terms. Empty falls once a
// sample has been rendered, later if it waits behind earlier samples.
// Reset clears the phase, selects saw and empties both queues.
// When the receiver stalls, two samples wait in the result queue, the
// renderer holds one more, the command queue fills and full rises.
// ----------------------------------------------------------------------------
module polyblep_oscillator #(
    parameter int PHASE_BITS      = pbo_pkg::PBO_PHASE_BITS,
    parameter int SINE_TABLE_BITS = pbo_pkg::PBO_SINE_TABLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [pbo_pkg::INC_W-1:0]            i_phase_increment,
    input  logic                                 i_restart,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [pbo_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pbo_pkg::WAVE_W-1:0]           i_cfg_data
);
    import pbo_pkg::*;

    localparam int CMD_W = $bits(t_ctl) + 3 * PHASE_BITS + ACC_W + SINE_TABLE_BITS;

    t_wave                       r_waveform_select;
    logic                        w_cmd_push, w_cmd_full, w_cmd_empty, w_cmd_pop;
    logic [CMD_W-1:0]            w_cmd_in, w_cmd_out;
    t_ctl                        w_ctl_in, w_ctl_out;
    logic [PHASE_BITS-1:0]       w_div_in, w_num_a_in, w_num_b_in;
    logic [PHASE_BITS-1:0]       w_div_out, w_num_a_out, w_num_b_out;
    logic signed [ACC_W-1:0]     w_base_in, w_base_out;
    logic [SINE_TABLE_BITS-1:0]  w_idx_in, w_idx_out;
    logic                        w_res_push, w_res_full;
    logic [SAMPLE_W-1:0]         w_res_data, w_res_out;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform_select <= WAVE_SAW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_waveform_select <= i_cfg_data;
        end
    end

    pbo_front #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_phase_increment (i_phase_increment),
        .i_restart         (i_restart),
        .i_waveform_select (r_waveform_select),
        .i_queue_full      (w_cmd_full),
        .o_cmd_push        (w_cmd_push),
        .o_ctl             (w_ctl_in),
        .o_divisor         (w_div_in),
        .o_num_a           (w_num_a_in),
        .o_num_b           (w_num_b_in),
        .o_base            (w_base_in),
        .o_sine_idx        (w_idx_in)
    );

    assign w_cmd_in = {w_ctl_in, w_div_in, w_num_a_in, w_num_b_in, w_base_in, w_idx_in};
    assign {w_ctl_out, w_div_out, w_num_a_out, w_num_b_out, w_base_out, w_idx_out} = w_cmd_out;

    pbo_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_cmd_push),
        .i_wr_data (w_cmd_in),
        .o_full    (w_cmd_full),
        .i_rd_en   (w_cmd_pop),
        .o_rd_data (w_cmd_out),
        .o_empty   (w_cmd_empty)
    );

    pbo_back #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_ctl       (w_ctl_out),
        .i_divisor   (w_div_out),
        .i_num_a     (w_num_a_out),
        .i_num_b     (w_num_b_out),
        .i_base      (w_base_out),
        .i_sine_idx  (w_idx_out),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_data)
    );

    pbo_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_res_push),
        .i_wr_data (w_res_data),
        .o_full    (w_res_full),
        .i_rd_en   (pop),
        .o_rd_data (w_res_out),
        .o_empty   (empty)
    );

    assign o_sample_out = $signed(w_res_out);

endmodule

### hdl/pbo_checker.sv
// ----------------------------------------------------------------------------
// pbo_assertions
// Port-level checks of the oscillator: transaction accounting and output hold.
// ----------------------------------------------------------------------------
module pbo_assertions (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 push,
    input logic                                 full,
    input logic                                 empty,
    input logic                                 pop,
    input logic signed [pbo_pkg::SAMPLE_W-1:0]  o_sample_out
);
    import pbo_pkg::*;

    localparam int CNT_W = $clog2(PIPE_CAPACITY + 2);

    logic [CNT_W-1:0] r_outstanding, n_outstanding;

    assign n_outstanding = r_outstanding + CNT_W'(push && !full) - CNT_W'(pop && !empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_outstanding != '0))
        else $error("result shown with no transaction outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= CNT_W'(PIPE_CAPACITY))
        else $error("more transactions taken than the block can hold");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sample_out)))
        else $error("stalled result changed or vanished");

endmodule

bind polyblep_oscillator pbo_assertions u_pbo_assertions (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_sample_out (o_sample_out)
);
